### rtl/m3inv_pkg.sv
// ----------------------------------------------------------------------------
// m3inv_pkg
// Shared constants for the 3x3 fixed-point matrix inverse pipeline.
// ----------------------------------------------------------------------------
package m3inv_pkg;

	// port width of every matrix element and result field
	localparam int unsigned FIELD_W = 32;

	// default element format, signed Q16.16
	localparam int unsigned DEF_FRAC_BITS = 16;
	localparam int unsigned DEF_ELEM_BITS = 32;

	// matrix lanes
	localparam int unsigned NLANE = 9;

	// cofactor terms per inverse element: e[p]*e[q] - e[r]*e[s], row-major indexes
	localparam int unsigned COF_IDX [NLANE][4] = '{
		'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
		'{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
	};

endpackage

### rtl/m3inv_front.sv
// ----------------------------------------------------------------------------
// m3inv_front
// Products, cofactors and exact determinant, five pipeline stages.
// ----------------------------------------------------------------------------
module m3inv_front #(
	parameter int unsigned ELEM_BITS = m3inv_pkg::DEF_ELEM_BITS
) (
	input  logic                                         clk,
	input  logic [4:0]                                   ld,
	input  logic [m3inv_pkg::NLANE-1:0][ELEM_BITS-1:0]   elem,
	output logic [m3inv_pkg::NLANE-1:0][2*ELEM_BITS:0]   cof,
	output logic [3*ELEM_BITS+2:0]                       det
);
	import m3inv_pkg::*;

	localparam int unsigned E  = ELEM_BITS;
	localparam int unsigned PW = 2 * E;
	localparam int unsigned CW = 2 * E + 1;
	localparam int unsigned DW = 3 * E + 3;

	logic signed [PW-1:0] p0_s1 [NLANE];
	logic signed [PW-1:0] p1_s1 [NLANE];
	logic signed [E-1:0]  r_s1  [3];
	logic signed [CW-1:0] c_s2  [NLANE];
	logic signed [E-1:0]  r_s2  [3];
	logic signed [CW-1:0] c_s3  [NLANE];
	logic signed [CW-1:0] lo_s3 [3];
	logic signed [CW-1:0] hi_s3 [3];
	logic signed [CW-1:0] c_s4  [NLANE];
	logic signed [DW-1:0] t_s4  [3];
	logic signed [CW-1:0] c_s5  [NLANE];
	logic signed [DW-1:0] det_s5;

	// stage 1: pair products of every cofactor, keep first row
	always_ff @(posedge clk) begin
		if (ld[0]) begin
			for (int i = 0; i < NLANE; i++) begin
				p0_s1[i] <= $signed(elem[COF_IDX[i][0]]) * $signed(elem[COF_IDX[i][1]]);
				p1_s1[i] <= $signed(elem[COF_IDX[i][2]]) * $signed(elem[COF_IDX[i][3]]);
			end
			for (int j = 0; j < 3; j++)
				r_s1[j] <= $signed(elem[j]);
		end
	end

	// stage 2: cofactors
	always_ff @(posedge clk) begin
		if (ld[1]) begin
			for (int i = 0; i < NLANE; i++)
				c_s2[i] <= CW'(p0_s1[i]) - CW'(p1_s1[i]);
			r_s2 <= r_s1;
		end
	end

	// stage 3: first-row expansion, cofactor split into high and low halves
	always_ff @(posedge clk) begin
		if (ld[2]) begin
			for (int j = 0; j < 3; j++) begin
				lo_s3[j] <= r_s2[j] * $signed({1'b0, c_s2[3*j][E-1:0]});
				hi_s3[j] <= r_s2[j] * $signed(c_s2[3*j][CW-1:E]);
			end
			c_s3 <= c_s2;
		end
	end

	// stage 4: recombine halves of each term
	always_ff @(posedge clk) begin
		if (ld[3]) begin
			for (int j = 0; j < 3; j++)
				t_s4[j] <= (DW'(hi_s3[j]) <<< E) + DW'(lo_s3[j]);
			c_s4 <= c_s3;
		end
	end

	// stage 5: determinant
	always_ff @(posedge clk) begin
		if (ld[4]) begin
			det_s5 <= t_s4[0] + t_s4[1] + t_s4[2];
			c_s5   <= c_s4;
		end
	end

	always_comb begin
		for (int i = 0; i < NLANE; i++)
			cof[i] = c_s5[i];
		det = det_s5;
	end

endmodule

### rtl/m3inv_prep.sv
// ----------------------------------------------------------------------------
// m3inv_prep
// Magnitudes, signs, dividends and range check ahead of the divider.
// ----------------------------------------------------------------------------
module m3inv_prep #(
	parameter int unsigned FRAC_BITS = m3inv_pkg::DEF_FRAC_BITS,
	parameter int unsigned ELEM_BITS = m3inv_pkg::DEF_ELEM_BITS,
	parameter int unsigned W         = 4 * ELEM_BITS + 4,
	parameter int unsigned SBW       = 3 * ELEM_BITS + 23
) (
	input  logic                                       clk,
	input  logic [1:0]                                 ld,
	input  logic [m3inv_pkg::NLANE-1:0][2*ELEM_BITS:0] cof,
	input  logic [3*ELEM_BITS+2:0]                     det,
	output logic [m3inv_pkg::NLANE-1:0][W-1:0]         rem,
	output logic [3*ELEM_BITS+2:0]                     dabs,
	output logic [SBW-1:0]                             sb
);
	import m3inv_pkg::*;

	localparam int unsigned E  = ELEM_BITS;
	localparam int unsigned F  = FRAC_BITS;
	localparam int unsigned CW = 2 * E + 1;
	localparam int unsigned DW = 3 * E + 3;
	localparam int unsigned QW = E + 1;

	logic [CW-1:0]     cabs_s6 [NLANE];
	logic [NLANE-1:0]  neg_s6;
	logic [DW-1:0]     dabs_s6;
	logic              dneg_s6;
	logic              dzero_s6;
	logic [W-1:0]      rem_s7 [NLANE];
	logic [NLANE-1:0]  ovf_s7;
	logic [NLANE-1:0]  neg_s7;
	logic [DW-1:0]     dabs_s7;
	logic [DW-1:0]     tmag_s7;
	logic              dneg_s7;
	logic              dzero_s7;
	logic [DW:0]       tsum;
	logic [W-1:0]      num    [NLANE];

	// stage 6: absolute values and result signs
	always_ff @(posedge clk) begin
		if (ld[0]) begin
			for (int i = 0; i < NLANE; i++) begin
				cabs_s6[i] <= cof[i][CW-1] ? (~cof[i] + CW'(1)) : cof[i];
				neg_s6[i]  <= cof[i][CW-1] ^ det[DW-1];
			end
			dabs_s6  <= det[DW-1] ? (~det + DW'(1)) : det;
			dneg_s6  <= det[DW-1];
			dzero_s6 <= (det == '0);
		end
	end

	// dividends and rounded determinant magnitude
	always_comb begin
		for (int i = 0; i < NLANE; i++)
			num[i] = W'(cabs_s6[i]) << (2 * F);
		tsum = (DW + 1)'(dabs_s6) + ((DW + 1)'(1) << (2 * F - 1));
	end

	// stage 7: quotient overflow check against the divider width
	always_ff @(posedge clk) begin
		if (ld[1]) begin
			for (int i = 0; i < NLANE; i++) begin
				rem_s7[i] <= num[i];
				ovf_s7[i] <= (num[i] >= (W'(dabs_s6) << QW));
			end
			neg_s7   <= neg_s6;
			dabs_s7  <= dabs_s6;
			tmag_s7  <= DW'(tsum >> (2 * F));
			dneg_s7  <= dneg_s6;
			dzero_s7 <= dzero_s6;
		end
	end

	always_comb begin
		for (int i = 0; i < NLANE; i++)
			rem[i] = rem_s7[i];
		dabs = dabs_s7;
		sb   = {dneg_s7, dzero_s7, neg_s7, ovf_s7, tmag_s7};
	end

endmodule

### rtl/m3inv_divstep.sv
// ----------------------------------------------------------------------------
// m3inv_divstep
// One restoring division step for all nine lanes, one quotient bit.
// ----------------------------------------------------------------------------
module m3inv_divstep #(
	parameter int unsigned ELEM_BITS = m3inv_pkg::DEF_ELEM_BITS,
	parameter int unsigned W         = 4 * ELEM_BITS + 4,
	parameter int unsigned SBW       = 3 * ELEM_BITS + 23,
	parameter int unsigned SHIFT     = 0
) (
	input  logic                                   clk,
	input  logic                                   ld,
	input  logic [m3inv_pkg::NLANE-1:0][W-1:0]     rem_in,
	input  logic [m3inv_pkg::NLANE-1:0][ELEM_BITS:0] q_in,
	input  logic [3*ELEM_BITS+2:0]                 dabs_in,
	input  logic [SBW-1:0]                         sb_in,
	output logic [m3inv_pkg::NLANE-1:0][W-1:0]     rem_out,
	output logic [m3inv_pkg::NLANE-1:0][ELEM_BITS:0] q_out,
	output logic [3*ELEM_BITS+2:0]                 dabs_out,
	output logic [SBW-1:0]                         sb_out
);
	import m3inv_pkg::*;

	localparam int unsigned DW = 3 * ELEM_BITS + 3;
	localparam logic [ELEM_BITS:0] QBIT = (ELEM_BITS + 1)'(1) << SHIFT;

	logic [W-1:0]              dsh;
	logic [NLANE-1:0][W-1:0]   rem_sd;
	logic [NLANE-1:0][ELEM_BITS:0] q_sd;
	logic [DW-1:0]             dabs_sd;
	logic [SBW-1:0]            sb_sd;

	assign dsh = W'(dabs_in) << SHIFT;

	// trial subtract of the shifted divisor
	always_ff @(posedge clk) begin
		if (ld) begin
			for (int i = 0; i < NLANE; i++) begin
				if (rem_in[i] >= dsh) begin
					rem_sd[i] <= rem_in[i] - dsh;
					q_sd[i]   <= q_in[i] | QBIT;
				end else begin
					rem_sd[i] <= rem_in[i];
					q_sd[i]   <= q_in[i] & ~QBIT;
				end
			end
			dabs_sd <= dabs_in;
			sb_sd   <= sb_in;
		end
	end

	assign rem_out  = rem_sd;
	assign q_out    = q_sd;
	assign dabs_out = dabs_sd;
	assign sb_out   = sb_sd;

endmodule

### rtl/m3inv_out.sv
// ----------------------------------------------------------------------------
// m3inv_out
// Rounding, sign, saturation and singular-matrix substitution; output stage.
// ----------------------------------------------------------------------------
module m3inv_out #(
	parameter int unsigned FRAC_BITS = m3inv_pkg::DEF_FRAC_BITS,
	parameter int unsigned ELEM_BITS = m3inv_pkg::DEF_ELEM_BITS,
	parameter int unsigned W         = 4 * ELEM_BITS + 4,
	parameter int unsigned SBW       = 3 * ELEM_BITS + 23
) (
	input  logic                                             clk,
	input  logic                                             ld,
	input  logic [m3inv_pkg::NLANE-1:0][W-1:0]               rem,
	input  logic [m3inv_pkg::NLANE-1:0][ELEM_BITS:0]         q,
	input  logic [3*ELEM_BITS+2:0]                           dabs,
	input  logic [SBW-1:0]                                   sb,
	output logic [m3inv_pkg::NLANE-1:0][m3inv_pkg::FIELD_W-1:0] b,
	output logic                                             invertible,
	output logic [m3inv_pkg::FIELD_W-1:0]                    determinant
);
	import m3inv_pkg::*;

	localparam int unsigned E  = ELEM_BITS;
	localparam int unsigned F  = FRAC_BITS;
	localparam int unsigned DW = 3 * E + 3;
	localparam int unsigned QW = E + 1;
	localparam logic [E-1:0]  MAXV = {1'b0, {(E - 1){1'b1}}};
	localparam logic [E-1:0]  MINV = {1'b1, {(E - 1){1'b0}}};
	localparam logic [E-1:0]  ONE  = (F >= E - 1) ? MAXV : (E'(1) << F);
	localparam logic [QW:0]   MAXM = (QW + 1)'(MAXV);
	localparam logic [QW:0]   MINM = (QW + 1)'(MINV);

	logic [DW-1:0]     tmag;
	logic [NLANE-1:0]  ovf;
	logic [NLANE-1:0]  neg;
	logic              dzero;
	logic              dneg;
	logic [QW:0]       m    [NLANE];
	logic [E-1:0]      res  [NLANE];
	logic [E-1:0]      dres;
	logic [NLANE-1:0][FIELD_W-1:0] b_so;
	logic              inv_so;
	logic [FIELD_W-1:0] det_so;

	assign {dneg, dzero, neg, ovf, tmag} = sb;

	// round to nearest, then saturate each inverse element; saturate the determinant
	always_comb begin
		for (int i = 0; i < NLANE; i++) begin
			m[i] = (QW + 1)'(q[i])
				+ (QW + 1)'(((W + 1)'(rem[i]) << 1) >= (W + 1)'(dabs));
			if (neg[i])
				res[i] = (ovf[i] || m[i] > MINM) ? MINV : (~m[i][E-1:0] + E'(1));
			else
				res[i] = (ovf[i] || m[i] > MAXM) ? MAXV : m[i][E-1:0];
		end
		if (dneg)
			dres = (tmag > DW'(MINM)) ? MINV : (~tmag[E-1:0] + E'(1));
		else
			dres = (tmag > DW'(MAXM)) ? MAXV : tmag[E-1:0];
	end

	// output stage, identity for a singular matrix
	always_ff @(posedge clk) begin
		if (ld) begin
			for (int i = 0; i < NLANE; i++) begin
				if (dzero)
					b_so[i] <= (i % 4 == 0) ? FIELD_W'($signed(ONE)) : '0;
				else
					b_so[i] <= FIELD_W'($signed(res[i]));
			end
			inv_so <= !dzero;
			det_so <= dzero ? '0 : FIELD_W'($signed(dres));
		end
	end

	assign b           = b_so;
	assign invertible  = inv_so;
	assign determinant = det_so;

endmodule

### rtl/matrix3_inverse_determinant.sv
// ----------------------------------------------------------------------------
// matrix3_inverse_determinant
// 3x3 fixed-point matrix inverse by adjugate over determinant, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input item: elements a11..a33, signed fixed point with FRAC_BITS fraction
//   bits in the low ELEM_BITS bits of each port. Output item: inverse b11..b33,
//   invertible flag and determinant, saturated to the element range and
//   sign-extended. A singular matrix gives the identity, invertible low and a
//   zero determinant.
//   Both channels use valid/stall; an item moves when valid is high and stall
//   is low. The pipeline holds five stages of products and determinant, two
//   of preparation, one restoring division step per quotient bit (ELEM_BITS
//   + 1 stages, nine lanes each) and the output stage. Throughput is one item
//   per cycle while the receiver does not stall.
//   When the receiver stalls, the output holds and the pipeline keeps filling
//   its empty stages; in_stall rises only once every stage holds an item.
//   Reset clears all stage valid bits; no results are pending afterwards.
// ----------------------------------------------------------------------------
module matrix3_inverse_determinant #(
	parameter int unsigned FRAC_BITS = m3inv_pkg::DEF_FRAC_BITS,
	parameter int unsigned ELEM_BITS = m3inv_pkg::DEF_ELEM_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [m3inv_pkg::FIELD_W-1:0]  a11,
	input  logic [m3inv_pkg::FIELD_W-1:0]  a12,
	input  logic [m3inv_pkg::FIELD_W-1:0]  a13,
	input  logic [m3inv_pkg::FIELD_W-1:0]  a21,
	input  logic [m3inv_pkg::FIELD_W-1:0]  a22,
	input  logic [m3inv_pkg::FIELD_W-1:0]  a23,
	input  logic [m3inv_pkg::FIELD_W-1:0]  a31,
	input  logic [m3inv_pkg::FIELD_W-1:0]  a32,
	input  logic [m3inv_pkg::FIELD_W-1:0]  a33,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [m3inv_pkg::FIELD_W-1:0]  b11,
	output logic [m3inv_pkg::FIELD_W-1:0]  b12,
	output logic [m3inv_pkg::FIELD_W-1:0]  b13,
	output logic [m3inv_pkg::FIELD_W-1:0]  b21,
	output logic [m3inv_pkg::FIELD_W-1:0]  b22,
	output logic [m3inv_pkg::FIELD_W-1:0]  b23,
	output logic [m3inv_pkg::FIELD_W-1:0]  b31,
	output logic [m3inv_pkg::FIELD_W-1:0]  b32,
	output logic [m3inv_pkg::FIELD_W-1:0]  b33,
	output logic                           invertible,
	output logic [m3inv_pkg::FIELD_W-1:0]  determinant
);
	import m3inv_pkg::*;

	localparam int unsigned E   = ELEM_BITS;
	localparam int unsigned F   = FRAC_BITS;
	localparam int unsigned CW  = 2 * E + 1;
	localparam int unsigned DW  = 3 * E + 3;
	localparam int unsigned QW  = E + 1;
	localparam int unsigned NW  = CW + 2 * F;
	localparam int unsigned W   = (NW > DW + QW) ? NW : DW + QW;
	localparam int unsigned SBW = DW + 2 * NLANE + 2;
	localparam int unsigned NS  = 7 + QW + 1;

	logic [NS-1:0]                vld_q;
	logic [NS-1:0]                ld;
	logic [NLANE-1:0][E-1:0]      elem;
	logic [NLANE-1:0][CW-1:0]     cof;
	logic [DW-1:0]                det;
	logic [NLANE-1:0][W-1:0]      rem_p  [QW+1];
	logic [NLANE-1:0][QW-1:0]     q_p    [QW+1];
	logic [DW-1:0]                dabs_p [QW+1];
	logic [SBW-1:0]               sb_p   [QW+1];
	logic [NLANE-1:0][FIELD_W-1:0] b;

	// element lanes, row-major, low bits only
	assign elem = {a33[E-1:0], a32[E-1:0], a31[E-1:0],
	               a23[E-1:0], a22[E-1:0], a21[E-1:0],
	               a13[E-1:0], a12[E-1:0], a11[E-1:0]};

	// per-stage load enables: a stage loads when empty or when it drains
	always_comb begin
		ld[NS-1] = !vld_q[NS-1] || !out_stall;
		for (int k = NS - 2; k >= 0; k--)
			ld[k] = !vld_q[k] || ld[k+1];
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[0])
				vld_q[0] <= in_valid;
			for (int k = 1; k < NS; k++)
				if (ld[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	assign in_stall  = !ld[0];
	assign out_valid = vld_q[NS-1];

	m3inv_front #(
		.ELEM_BITS (E)
	) u_front (
		.clk  (clk),
		.ld   (ld[4:0]),
		.elem (elem),
		.cof  (cof),
		.det  (det)
	);

	m3inv_prep #(
		.FRAC_BITS (F),
		.ELEM_BITS (E),
		.W         (W),
		.SBW       (SBW)
	) u_prep (
		.clk  (clk),
		.ld   (ld[6:5]),
		.cof  (cof),
		.det  (det),
		.rem  (rem_p[0]),
		.dabs (dabs_p[0]),
		.sb   (sb_p[0])
	);

	assign q_p[0] = '0;

	// division steps, most significant quotient bit first
	for (genvar s = 0; s < QW; s++) begin : g_div
		m3inv_divstep #(
			.ELEM_BITS (E),
			.W         (W),
			.SBW       (SBW),
			.SHIFT     (QW - 1 - s)
		) u_step (
			.clk      (clk),
			.ld       (ld[7+s]),
			.rem_in   (rem_p[s]),
			.q_in     (q_p[s]),
			.dabs_in  (dabs_p[s]),
			.sb_in    (sb_p[s]),
			.rem_out  (rem_p[s+1]),
			.q_out    (q_p[s+1]),
			.dabs_out (dabs_p[s+1]),
			.sb_out   (sb_p[s+1])
		);
	end

	m3inv_out #(
		.FRAC_BITS (F),
		.ELEM_BITS (E),
		.W         (W),
		.SBW       (SBW)
	) u_out (
		.clk         (clk),
		.ld          (ld[NS-1]),
		.rem         (rem_p[QW]),
		.q           (q_p[QW]),
		.dabs        (dabs_p[QW]),
		.sb          (sb_p[QW]),
		.b           (b),
		.invertible  (invertible),
		.determinant (determinant)
	);

	assign b11 = b[0];
	assign b12 = b[1];
	assign b13 = b[2];
	assign b21 = b[3];
	assign b22 = b[4];
	assign b23 = b[5];
	assign b31 = b[6];
	assign b32 = b[7];
	assign b33 = b[8];

	// back-pressure reaches the input only with every stage full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (&vld_q))
		else $error("input stalled while a stage is empty");

	// an accepted item occupies the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_q[0])
		else $error("accepted item lost at pipeline entry");

	// singular result carries zero determinant and zero b12 and b21
	a_singular: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !invertible) |-> (determinant == '0 && b12 == '0 && b21 == '0))
		else $error("singular result not the identity");

endmodule
